// File: hdl/uart_tx_with_fifo_defines.svh
// Assertion macros used by the transmit FIFO of the UART transmitter RTL.
`ifndef UART_TX_WITH_FIFO_DEFINES_SVH
`define UART_TX_WITH_FIFO_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define UTF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the following clock cycle.
`define UTF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/utf_pkg.sv
// Shared types, constants and codes of the UART transmitter.
package utf_pkg;

   localparam int TX_FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W    = (TX_FIFO_DEPTH > 1) ? $clog2(TX_FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W    = $clog2(TX_FIFO_DEPTH + 1);
   localparam int FREE_W        = 4;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   localparam logic [2:0] REG_CLOCK_DIVIDER    = 3'd0;
   localparam logic [2:0] REG_PARITY_MODE      = 3'd1;
   localparam logic [2:0] REG_TWO_STOP_BITS    = 3'd2;
   localparam logic [2:0] REG_TX_IRQ_ENABLE    = 3'd3;
   localparam logic [2:0] REG_BIT_LEVEL_ENABLE = 3'd4;

   localparam logic [1:0] PARITY_EVEN = 2'd1;
   localparam logic [1:0] PARITY_ODD  = 2'd2;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_DATA   = 3'd2;
   localparam logic [2:0] PH_PARITY = 3'd3;
   localparam logic [2:0] PH_STOP1  = 3'd4;
   localparam logic [2:0] PH_STOP2  = 3'd5;

   typedef struct packed {
      logic [15:0] clock_divider;
      logic [1:0]  parity_mode;
      logic        two_stop_bits;
      logic        tx_irq_enable;
      logic        bit_level_enable;
   } cfg_type;

   typedef struct packed {
      logic [7:0]            head;
      logic                  has_data;
      logic [FIFO_CNT_W-1:0] count_next;
      logic                  dropped;
   } fifo_status_type;

   typedef struct packed {
      logic              line_level;
      logic [FREE_W-1:0] fifo_free;
      logic              tx_irq_pending;
      logic              busy_res;
      logic              write_dropped;
   } rsp_type;

endpackage

// File: hdl/uart_tx_with_fifo.sv
// Top level of the UART transmitter with transmit FIFO.
// Each request beat is a tick of the bit timer or a byte write to the
// eight-entry FIFO, and yields exactly one response beat with the line level,
// free FIFO entries, busy flag, TX-empty interrupt and a drop flag for a write
// that met a full FIFO. One beat is taken per clock cycle: the FIFO, the frame
// sequencer and the bit timer update in the accepting cycle, and the response
// goes into a two-entry output buffer, so req_ready falls only while both
// buffer entries hold responses that have not been taken. Each serial bit lasts
// clock_divider+1 ticks; the frame is a low start bit, eight data bits MSB
// first, an optional parity bit and one or two stop bits.
module uart_tx_with_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [7:0]                     req_tx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_line_level,
   output logic [utf_pkg::FREE_W-1:0]     rsp_fifo_free,
   output logic                           rsp_tx_irq_pending,
   output logic                           rsp_busy_res,
   output logic                           rsp_write_dropped,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [utf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [utf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [utf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import utf_pkg::*;

   cfg_type               cfg;
   fifo_status_type       fifo_st;
   rsp_type               rsp_new;
   rsp_type               rsp_out;
   logic                  accept;
   logic                  tick;
   logic                  wr;
   logic                  pop;
   logic                  line_level;
   logic                  busy;
   logic [FIFO_CNT_W-1:0] free_cnt;

   assign accept = req_valid && req_ready;
   assign tick   = accept && (req_action == ACT_TICK);
   assign wr     = accept && (req_action == ACT_WRITE);

   utf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   utf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (wr),
      .push_byte (req_tx_byte),
      .pop       (pop),
      .flush     (accept && !cfg.bit_level_enable),
      .status    (fifo_st)
   );

   utf_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .item       (accept),
      .tick       (tick),
      .cfg        (cfg),
      .fifo_st    (fifo_st),
      .pop        (pop),
      .line_level (line_level),
      .busy       (busy)
   );

   assign free_cnt               = FIFO_CNT_W'(TX_FIFO_DEPTH) - fifo_st.count_next;
   assign rsp_new.line_level     = line_level;
   assign rsp_new.fifo_free      = FREE_W'(free_cnt);
   assign rsp_new.tx_irq_pending = cfg.tx_irq_enable && (fifo_st.count_next == '0);
   assign rsp_new.busy_res       = busy;
   assign rsp_new.write_dropped  = fifo_st.dropped;

   utf_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_new),
      .can_take  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_out)
   );

   assign rsp_line_level     = rsp_out.line_level;
   assign rsp_fifo_free      = rsp_out.fifo_free;
   assign rsp_tx_irq_pending = rsp_out.tx_irq_pending;
   assign rsp_busy_res       = rsp_out.busy_res;
   assign rsp_write_dropped  = rsp_out.write_dropped;

endmodule

// File: hdl/utf_csr.sv
// Configuration register file behind the APB-style port.
module utf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [utf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [utf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [utf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output utf_pkg::cfg_type              cfg
);
   import utf_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CLOCK_DIVIDER:    cfg_in.clock_divider    = csr_pwdata[15:0];
            REG_PARITY_MODE:      cfg_in.parity_mode      = csr_pwdata[1:0];
            REG_TWO_STOP_BITS:    cfg_in.two_stop_bits    = csr_pwdata[0];
            REG_TX_IRQ_ENABLE:    cfg_in.tx_irq_enable    = csr_pwdata[0];
            REG_BIT_LEVEL_ENABLE: cfg_in.bit_level_enable = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CLOCK_DIVIDER:    csr_prdata = {16'd0, cfg_ff.clock_divider};
         REG_PARITY_MODE:      csr_prdata = {30'd0, cfg_ff.parity_mode};
         REG_TWO_STOP_BITS:    csr_prdata = {31'd0, cfg_ff.two_stop_bits};
         REG_TX_IRQ_ENABLE:    csr_prdata = {31'd0, cfg_ff.tx_irq_enable};
         REG_BIT_LEVEL_ENABLE: csr_prdata = {31'd0, cfg_ff.bit_level_enable};
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_divider    <= '0;
         cfg_ff.parity_mode      <= '0;
         cfg_ff.two_stop_bits    <= 1'b0;
         cfg_ff.tx_irq_enable    <= 1'b0;
         cfg_ff.bit_level_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hdl/utf_fifo.sv
// Transmit byte FIFO with drop on full and flush.
`include "uart_tx_with_fifo_defines.svh"
module utf_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [7:0]               push_byte,
   input  logic                     pop,
   input  logic                     flush,
   output utf_pkg::fifo_status_type status
);
   import utf_pkg::*;

   logic [7:0]            fifo_store_ff [TX_FIFO_DEPTH];
   logic [7:0]            head_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  full;
   logic                  wr_en;

   function automatic logic [FIFO_PTR_W-1:0] next_ptr(input logic [FIFO_PTR_W-1:0] p);
      logic [FIFO_PTR_W-1:0] r;
      if (p == FIFO_PTR_W'(TX_FIFO_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign full  = (count_ff >= FIFO_CNT_W'(TX_FIFO_DEPTH));
   assign wr_en = push && !full;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
         count_in  = count_ff + 1'b1;
      end else if (pop) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
         count_in  = count_ff - 1'b1;
      end
      if (flush) begin
         rd_ptr_in = wr_ptr_in;
         count_in  = '0;
      end
   end

   assign status.head       = head_ff;
   assign status.has_data   = (count_ff != '0);
   assign status.count_next = count_in;
   assign status.dropped    = push && full;

   // hold the entry at the next read pointer, bypassing a write to that slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fifo_store_ff[wr_ptr_ff] <= push_byte;
      end
      if (wr_en && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_byte;
      end else begin
         head_ff <= fifo_store_ff[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   `UTF_ASSERT(a_count_bound, count_ff <= FIFO_CNT_W'(TX_FIFO_DEPTH), "fifo count over depth")
   `UTF_ASSERT(a_push_pop_excl, !(push && pop), "push and pop in one beat")
   `UTF_ASSERT(a_pop_nonempty, !pop || (count_ff != '0), "pop from empty fifo")
   `UTF_ASSERT_NEXT(a_flush_empty, flush, count_ff == '0, "fifo not empty after flush")

endmodule

// File: hdl/utf_framer.sv
// Frame sequencer: start, data, parity and stop bits with bit timing.
module utf_framer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item,
   input  logic                     tick,
   input  utf_pkg::cfg_type         cfg,
   input  utf_pkg::fifo_status_type fifo_st,
   output logic                     pop,
   output logic                     line_level,
   output logic                     busy
);
   import utf_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  phase_mid;
   logic [2:0]  bit_ff, bit_in;
   logic [15:0] tick_ff, tick_in;
   logic [7:0]  byte_ff, byte_in;
   logic        parity_on;

   assign parity_on = (cfg.parity_mode == PARITY_EVEN) || (cfg.parity_mode == PARITY_ODD);

   always_comb begin
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      tick_in   = tick_ff;
      byte_in   = byte_ff;
      phase_mid = phase_ff;
      pop       = 1'b0;
      if (tick && cfg.bit_level_enable) begin
         if (phase_ff != PH_IDLE && tick_ff < cfg.clock_divider) begin
            tick_in = tick_ff + 1'b1;
         end else begin
            if (phase_ff != PH_IDLE) begin
               tick_in = '0;
               unique case (phase_ff)
                  PH_START: begin
                     phase_mid = PH_DATA;
                     bit_in    = '0;
                  end
                  PH_DATA: begin
                     if (bit_ff != 3'd7) begin
                        bit_in = bit_ff + 1'b1;
                     end else begin
                        bit_in    = '0;
                        phase_mid = parity_on ? PH_PARITY : PH_STOP1;
                     end
                  end
                  PH_PARITY: phase_mid = PH_STOP1;
                  PH_STOP1:  phase_mid = cfg.two_stop_bits ? PH_STOP2 : PH_IDLE;
                  default:   phase_mid = PH_IDLE;
               endcase
            end
            phase_in = phase_mid;
            if (phase_mid == PH_IDLE && fifo_st.has_data) begin
               pop      = 1'b1;
               byte_in  = fifo_st.head;
               phase_in = PH_START;
               bit_in   = '0;
               tick_in  = '0;
            end
         end
      end
      if (item && !cfg.bit_level_enable) begin
         phase_in = PH_IDLE;
         bit_in   = '0;
         tick_in  = '0;
      end
   end

   always_comb begin
      unique case (phase_in)
         PH_START:  line_level = 1'b0;
         PH_DATA:   line_level = byte_in[3'd7 - bit_in];
         PH_PARITY: line_level = (cfg.parity_mode == PARITY_EVEN) ? ^byte_in : ~^byte_in;
         default:   line_level = 1'b1;
      endcase
   end

   assign busy = (phase_in != PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= '0;
         tick_ff  <= '0;
         byte_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
         byte_ff  <= byte_in;
      end
   end

endmodule

// File: hdl/utf_rsp_buf.sv
// Two-entry result buffer: output register plus skid stage.
module utf_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  utf_pkg::rsp_type push_data,
   output logic             can_take,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output utf_pkg::rsp_type rsp_data
);
   import utf_pkg::*;

   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_vld_ff, main_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   logic    drain;

   assign can_take  = !skid_vld_ff;
   assign rsp_valid = main_vld_ff;
   assign rsp_data  = main_ff;
   assign drain     = main_vld_ff && rsp_ready;

   always_comb begin
      main_in     = main_ff;
      skid_in     = skid_ff;
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (drain) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!main_vld_ff || drain) begin
         main_in     = push_data;
         main_vld_in = push;
      end else if (push) begin
         skid_in     = push_data;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

endmodule

// File: dv/uart_tx_with_fifo_tb.sv
// Self-checking testbench for the UART transmitter with its transmit FIFO.
module uart_tx_with_fifo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utf_pkg::*;

   localparam logic [1:0] PARITY_NONE     = 2'd0;
   localparam logic [1:0] PARITY_NONE_ALT = 2'd3;
   localparam logic [2:0] REG_UNMAPPED    = 3'd5;
   localparam int         BEAT_TARGET     = 1550;

   typedef struct {
      logic       action;
      logic [7:0] data;
   } req_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_action = ACT_TICK;
   logic [7:0]            req_tx_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_line_level;
   logic [FREE_W-1:0]     rsp_fifo_free;
   logic                  rsp_tx_irq_pending;
   logic                  rsp_busy_res;
   logic                  rsp_write_dropped;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   uart_tx_with_fifo dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_tx_byte        (req_tx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_line_level     (rsp_line_level),
      .rsp_fifo_free      (rsp_fifo_free),
      .rsp_tx_irq_pending (rsp_tx_irq_pending),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_write_dropped  (rsp_write_dropped),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   req_item_type pending_q[$];
   rsp_type      line_status_q[$];

   int beats_issued     = 0;
   int beats_checked    = 0;
   int fail_count       = 0;
   int writes_sent      = 0;
   int writes_dropped   = 0;
   int frames_begun     = 0;
   int settings_applied = 0;
   int send_gap         = 0;
   int stall_left       = 0;
   bit idle_on          = 1'b1;

   // transmitter shadow state
   cfg_type                shadow_cfg = '{clock_divider: 16'd0, parity_mode: PARITY_NONE,
                                          two_stop_bits: 1'b0, tx_irq_enable: 1'b0,
                                          bit_level_enable: 1'b1};
   logic [7:0]             fifo_mem [TX_FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  rd_ptr = '0;
   logic [FIFO_PTR_W-1:0]  wr_ptr = '0;
   int                     tx_count = 0;
   logic [7:0]             shift_reg = 8'h00;
   logic [2:0]             tx_phase = PH_IDLE;
   int                     bit_idx = 0;
   logic [15:0]            tick_cnt = 16'd0;

   function automatic logic [FIFO_PTR_W-1:0] next_slot(input logic [FIFO_PTR_W-1:0] p);
      return (p == FIFO_PTR_W'(TX_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic void load_next_byte();
      if (tx_phase == PH_IDLE && tx_count > 0) begin
         shift_reg = fifo_mem[rd_ptr];
         rd_ptr = next_slot(rd_ptr);
         tx_count--;
         tx_phase = PH_START;
         bit_idx = 0;
         tick_cnt = 16'd0;
         frames_begun++;
      end
   endfunction

   function automatic rsp_type advance_transmitter(input logic action, input logic [7:0] data);
      rsp_type r;
      logic    dropped;
      dropped = 1'b0;
      if (action == ACT_WRITE) begin
         writes_sent++;
         if (tx_count >= TX_FIFO_DEPTH) begin
            dropped = 1'b1;
            writes_dropped++;
         end else begin
            fifo_mem[wr_ptr] = data;
            wr_ptr = next_slot(wr_ptr);
            tx_count++;
         end
      end else if (shadow_cfg.bit_level_enable) begin
         if (tx_phase == PH_IDLE) begin
            load_next_byte();
         end else if (tick_cnt >= shadow_cfg.clock_divider) begin
            tick_cnt = 16'd0;
            case (tx_phase)
               PH_START: begin
                  tx_phase = PH_DATA;
                  bit_idx = 0;
               end
               PH_DATA: begin
                  if (bit_idx < 7) begin
                     bit_idx++;
                  end else begin
                     bit_idx = 0;
                     tx_phase = (shadow_cfg.parity_mode == PARITY_EVEN ||
                                 shadow_cfg.parity_mode == PARITY_ODD) ? PH_PARITY : PH_STOP1;
                  end
               end
               PH_PARITY: tx_phase = PH_STOP1;
               PH_STOP1: tx_phase = shadow_cfg.two_stop_bits ? PH_STOP2 : PH_IDLE;
               default: tx_phase = PH_IDLE;
            endcase
            load_next_byte();
         end else begin
            tick_cnt = tick_cnt + 16'd1;
         end
      end

      if (!shadow_cfg.bit_level_enable) begin
         tx_phase = PH_IDLE;
         bit_idx = 0;
         tick_cnt = 16'd0;
         tx_count = 0;
         rd_ptr = wr_ptr;
      end

      case (tx_phase)
         PH_START: r.line_level = 1'b0;
         PH_DATA: r.line_level = shift_reg[7 - bit_idx];
         PH_PARITY: r.line_level = (shadow_cfg.parity_mode == PARITY_EVEN) ?
                                   ^shift_reg : ~^shift_reg;
         default: r.line_level = 1'b1;
      endcase
      r.fifo_free      = FREE_W'(TX_FIFO_DEPTH - tx_count);
      r.tx_irq_pending = shadow_cfg.tx_irq_enable && tx_count == 0;
      r.busy_res       = tx_phase != PH_IDLE;
      r.write_dropped  = dropped;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // request driver; predicts on every accepted beat
   always @(posedge clock) begin : drive_req
      req_item_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            line_status_q.insert(line_status_q.size(),
                                 advance_transmitter(req_action, req_tx_byte));
         end
         if (req_valid && !req_ready) begin
            // hold the beat until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            cur = pending_q.pop_front();
            req_valid <= 1'b1;
            req_action <= cur.action;
            req_tx_byte <= cur.data;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_status_q.size() == 0) begin
            report_mismatch("response beat with nothing expected");
         end else begin
            want = line_status_q.pop_front();
            beats_checked++;
            if (rsp_line_level !== want.line_level)
               report_mismatch($sformatf("beat %0d line_level got %b want %b",
                  beats_checked, rsp_line_level, want.line_level));
            if (rsp_fifo_free !== want.fifo_free)
               report_mismatch($sformatf("beat %0d fifo_free got %0d want %0d",
                  beats_checked, rsp_fifo_free, want.fifo_free));
            if (rsp_tx_irq_pending !== want.tx_irq_pending)
               report_mismatch($sformatf("beat %0d tx_irq_pending got %b want %b",
                  beats_checked, rsp_tx_irq_pending, want.tx_irq_pending));
            if (rsp_busy_res !== want.busy_res)
               report_mismatch($sformatf("beat %0d busy_res got %b want %b",
                  beats_checked, rsp_busy_res, want.busy_res));
            if (rsp_write_dropped !== want.write_dropped)
               report_mismatch($sformatf("beat %0d write_dropped got %b want %b",
                  beats_checked, rsp_write_dropped, want.write_dropped));
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_CLOCK_DIVIDER: shadow_cfg.clock_divider = value[15:0];
         REG_PARITY_MODE: shadow_cfg.parity_mode = value[1:0];
         REG_TWO_STOP_BITS: shadow_cfg.two_stop_bits = value[0];
         REG_TX_IRQ_ENABLE: shadow_cfg.tx_irq_enable = value[0];
         REG_BIT_LEVEL_ENABLE: shadow_cfg.bit_level_enable = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [15:0] div, input logic [1:0] par,
                                input logic stop2, input logic irq, input logic ble);
      csr_write(REG_CLOCK_DIVIDER, {16'($urandom()), div});
      csr_write(REG_PARITY_MODE, {30'($urandom()), par});
      csr_write(REG_TWO_STOP_BITS, {31'($urandom()), stop2});
      csr_write(REG_TX_IRQ_ENABLE, {31'($urandom()), irq});
      csr_write(REG_BIT_LEVEL_ENABLE, {31'($urandom()), ble});
      if ($urandom_range(0, 3) == 0)
         csr_write(REG_UNMAPPED + 3'($urandom_range(0, 2)), $urandom());
      settings_applied++;
   endtask

   task automatic drain();
      while (beats_checked < beats_issued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_item(input logic action, input logic [7:0] data);
      req_item_type it;
      it.action = action;
      it.data = data;
      pending_q.insert(pending_q.size(), it);
      beats_issued++;
   endtask

   initial begin : stimulus
      logic [7:0]  directed_bytes [9];
      logic [15:0] div;
      logic [1:0]  par;
      logic        stop2, irq, ble;
      int          n, write_pct, r;

      directed_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h77};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill past full, then let the first frame shift out and the next follow back to back
      foreach (directed_bytes[i]) push_item(ACT_WRITE, directed_bytes[i]);
      repeat (14) push_item(ACT_TICK, 8'($urandom()));
      drain();

      for (int p = 0; beats_issued < BEAT_TARGET; p++) begin
         stop2 = 1'($urandom_range(0, 1));
         irq = 1'($urandom_range(0, 1));
         ble = 1'b1;
         case (p)
            0: begin div = 16'd0; par = PARITY_EVEN; stop2 = 1'b0; irq = 1'b1; end
            1: begin div = 16'd1; par = PARITY_ODD; stop2 = 1'b1; irq = 1'b1; end
            2: begin div = 16'd2; par = PARITY_NONE_ALT; stop2 = 1'b1; irq = 1'b0; end
            3: begin div = 16'd0; par = PARITY_NONE; irq = 1'b1; ble = 1'b0; end
            4: begin div = 16'hFFFF; par = PARITY_EVEN; end
            default: begin
               r = $urandom_range(0, 99);
               if (r < 60) div = 16'($urandom_range(0, 3));
               else if (r < 85) div = 16'($urandom_range(4, 12));
               else if (r < 96) div = 16'd0;
               else div = 16'hFFFF;
               par = 2'($urandom_range(0, 3));
               ble = $urandom_range(0, 9) != 0;
            end
         endcase
         apply_setting(div, par, stop2, irq, ble);

         r = $urandom_range(0, 9);
         if (r < 4) write_pct = 5;
         else if (r < 7) write_pct = 15;
         else if (r < 9) write_pct = 35;
         else write_pct = 70;
         n = (div == 16'hFFFF) ? 30 : $urandom_range(60, 160);
         idle_on = $urandom_range(0, 3) != 0;
         for (int k = 0; k < n; k++) begin
            push_item(($urandom_range(0, 99) < write_pct) ? ACT_WRITE : ACT_TICK,
                      ($urandom_range(0, 9) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                                  : 8'($urandom()));
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (line_status_q.size() != 0)
         report_mismatch($sformatf("%0d expected beats never arrived", line_status_q.size()));
      $display("run covered %0d beats across %0d register settings", beats_issued,
               settings_applied);
      $display("%0d byte writes (%0d lost to a full FIFO), %0d frames started",
               writes_sent, writes_dropped, frames_begun);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("run stopped by the watchdog");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
